// File: design/dlts_pkg.sv
// Package for the delta-list timeout scheduler: opcodes, result kinds,
// status codes and the sequencer state type. No dependencies.
`default_nettype none
package dlts_pkg;
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SCHED  = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	// Opcode with no meaning; the block ignores it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] KIND_SCHED  = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_EXPIRE = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ZERO   = 2'd2;
	localparam logic [1:0] ST_NOSUCH = 2'd3;

	localparam int MAX_RESULTS = 32;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_EXP,
		S_EXPW,
		S_WALK,
		S_INS,
		S_CAN
	} state_t;
endpackage
`default_nettype wire

// File: design/dlts_stream_if.sv
// Valid/ready stream interface carrying one word of a parameterized payload.
// Depends on nothing.
`default_nettype none
interface dlts_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/delta_list_timeout_scheduler_top.sv
// Top level of the delta-list timeout scheduler: slot memory and sequencer.
// Depends on dlts_pkg and dlts_stream_if.
//
// One word in, zero or more result words out; SLOTS must be a power of two.
// Slot state lives in a single synchronous memory (one read and one write
// port, registered read data); every access goes through it, at most one
// read and one write per cycle, and no entry is read in the cycle it is
// written. After reset a clearing pass writes every slot before the first
// word is taken. Each word is accepted in S_IDLE and its first entry read
// in S_RD. An empty-list tick, a tick that leaves the head counting, a
// rejected schedule, a failed cancel and an unknown opcode end there. A tick
// that expires entries visits S_EXP and S_EXPW per entry, waiting while the
// receiver holds off. A cancel rewrites successor, predecessor and freed slot
// in S_CAN. A schedule walks the list in S_WALK (the read port sets the
// rate), then writes new slot, successor, predecessor in S_INS. Each result
// word waits in an output register; no new word is taken until it is gone.
`default_nettype none
module delta_list_timeout_scheduler_top #(
	parameter int SLOTS = 32,
	parameter int DELAY_WIDTH = 32,
	parameter int HANDLE_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	dlts_stream_if.sink in_ch,
	dlts_stream_if.source out_ch
);
	import dlts_pkg::*;

	localparam int PW = $clog2(SLOTS + 1);
	localparam int IW = $clog2(SLOTS);
	localparam logic [PW-1:0] NIL = PW'(SLOTS);
	localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);
	localparam logic [HANDLE_WIDTH-1:0] HSTEP = HANDLE_WIDTH'(SLOTS);
	localparam logic [5:0] NEXP_MAX = 6'(MAX_RESULTS);

	typedef struct packed {
		logic [DELAY_WIDTH-1:0]  delta;
		logic [HANDLE_WIDTH-1:0] hnd;
		logic [PW-1:0]           nxt;
		logic [PW-1:0]           prv;
		logic                    act;
		logic [15:0]             cb;
		logic [31:0]             arg;
	} slot_t;

	slot_t mem [SLOTS];
	slot_t rd_q;
	logic [IW-1:0] ra, wa;
	logic re, we;
	slot_t wd;

	state_t state_q, state_n;
	logic [PW-1:0] head_q, free_q, cur_q, pre_q, s_q;
	logic [DELAY_WIDTH-1:0] prefix_q, dly_q;
	logic [1:0] op_q;
	logic [15:0] cb_q, ch_q;
	logic [31:0] arg_q;
	logic [5:0] nexp_q;
	logic [1:0] sub_q;
	slot_t sv_q, pe_q;
	logic ov_q;
	logic [1:0] ok_q, os_q;
	logic [15:0] oh_q, oc_q;
	logic [31:0] oa_q;
	logic ol_q;

	logic in_acc, out_acc, out_free;
	logic [1:0] in_op;
	logic [DELAY_WIDTH-1:0] sum, ins_delta;
	logic [HANDLE_WIDTH-1:0] new_hnd;
	logic hit, more, brk;
	logic out_load;
	logic [1:0] ok_n, os_n;
	logic [15:0] oh_n, oc_n;
	logic [31:0] oa_n;
	logic ol_n;

	// Memory: one read, one write port, registered read data.
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	assign in_ch.ready = (state_q == S_IDLE) && !ov_q;
	assign out_ch.valid = ov_q;
	assign out_ch.data = {ok_q, os_q, oh_q, oc_q, oa_q, ol_q};

	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_acc = ov_q && out_ch.ready;
	assign out_free = !ov_q || out_ch.ready;
	assign in_op = in_ch.data[97:96];

	// Walk compare, inserted delta and the cancel match.
	assign sum = prefix_q + rd_q.delta;
	assign brk = dly_q < sum;
	assign ins_delta = dly_q - prefix_q;
	assign new_hnd = sv_q.hnd + HSTEP;
	assign hit = rd_q.act && (32'(rd_q.hnd) == 32'(ch_q));
	// Another expiry follows when the cap allows and the successor is due now.
	assign more = (nexp_q < NEXP_MAX) && (sv_q.nxt != NIL) && (rd_q.delta == '0);

	// Next-state selection.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: if (cur_q == LAST_SLOT) state_n = S_IDLE;
			S_IDLE: if (in_acc) state_n = S_RD;
			S_RD: begin
				unique case (op_q)
					OP_TICK: begin
						if (head_q != NIL && rd_q.delta <= DELAY_WIDTH'(1))
							state_n = S_EXP;
						else
							state_n = S_IDLE;
					end
					OP_SCHED: begin
						if (dly_q == '0 || free_q == NIL) state_n = S_IDLE;
						else if (head_q == NIL) state_n = S_INS;
						else state_n = S_WALK;
					end
					OP_CANCEL: state_n = hit ? S_CAN : S_IDLE;
					default: state_n = S_IDLE;
				endcase
			end
			S_EXP: state_n = S_EXPW;
			S_EXPW: if (out_free) state_n = more ? S_EXP : S_IDLE;
			S_WALK: if (brk || rd_q.nxt == NIL) state_n = S_INS;
			S_INS: if (sub_q == 2'd2) state_n = S_IDLE;
			S_CAN: if (sub_q == 2'd2) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// Memory port control: one read and one write at most per cycle.
	always_comb begin
		re = 1'b0; we = 1'b0; ra = '0; wa = '0; wd = rd_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1; wa = cur_q[IW-1:0];
				wd = '0;
				wd.hnd = HANDLE_WIDTH'(cur_q);
				wd.nxt = cur_q + PW'(1);
			end
			S_IDLE: begin
				re = in_acc;
				ra = (in_op == OP_CANCEL) ? in_ch.data[IW-1:0] :
					(in_op == OP_SCHED) ? free_q[IW-1:0] : head_q[IW-1:0];
			end
			S_RD: begin
				unique case (op_q)
					OP_TICK: begin
						// The head keeps counting: write back its decremented delta.
						if (head_q != NIL && rd_q.delta > DELAY_WIDTH'(1)) begin
							we = 1'b1; wa = head_q[IW-1:0];
							wd.delta = rd_q.delta - DELAY_WIDTH'(1);
						end
					end
					OP_SCHED: begin
						if (dly_q != '0 && free_q != NIL && head_q != NIL) begin
							re = 1'b1; ra = head_q[IW-1:0];
						end
					end
					OP_CANCEL: begin
						if (hit && rd_q.nxt != NIL) begin
							re = 1'b1; ra = rd_q.nxt[IW-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			S_EXP: begin
				// Release the expiring slot to the free pool and fetch its successor.
				we = 1'b1; wa = cur_q[IW-1:0];
				wd = sv_q;
				wd.act = 1'b0; wd.delta = '0; wd.prv = '0; wd.nxt = free_q;
				if (sv_q.nxt != NIL) begin
					re = 1'b1; ra = sv_q.nxt[IW-1:0];
				end
			end
			S_WALK: begin
				if (!brk && rd_q.nxt != NIL) begin
					re = 1'b1; ra = rd_q.nxt[IW-1:0];
				end
			end
			S_INS: begin
				unique case (sub_q)
					2'd0: begin
						we = 1'b1; wa = s_q[IW-1:0];
						wd = sv_q;
						wd.hnd = new_hnd; wd.act = 1'b1; wd.cb = cb_q; wd.arg = arg_q;
						wd.prv = pre_q; wd.nxt = cur_q; wd.delta = ins_delta;
					end
					2'd1: begin
						if (cur_q != NIL) begin
							we = 1'b1; wa = cur_q[IW-1:0];
							wd.prv = s_q; wd.delta = rd_q.delta - ins_delta;
						end
					end
					2'd2: begin
						if (pre_q != NIL) begin
							we = 1'b1; wa = pre_q[IW-1:0];
							wd = pe_q; wd.nxt = s_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_CAN: begin
				unique case (sub_q)
					2'd0: begin
						// Successor takes over the removed delta; fetch the predecessor.
						if (sv_q.nxt != NIL) begin
							we = 1'b1; wa = sv_q.nxt[IW-1:0];
							wd.delta = rd_q.delta + sv_q.delta;
							wd.prv = (head_q == s_q) ? NIL : sv_q.prv;
						end
						if (head_q != s_q && sv_q.prv != NIL) begin
							re = 1'b1; ra = sv_q.prv[IW-1:0];
						end
					end
					2'd1: begin
						if (head_q != s_q && sv_q.prv != NIL) begin
							we = 1'b1; wa = sv_q.prv[IW-1:0];
							wd.nxt = sv_q.nxt;
						end
					end
					2'd2: begin
						we = 1'b1; wa = s_q[IW-1:0];
						wd = sv_q;
						wd.act = 1'b0; wd.delta = '0; wd.prv = '0; wd.nxt = free_q;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Result word selection.
	always_comb begin
		out_load = 1'b0;
		ok_n = KIND_SCHED; os_n = ST_OK; oh_n = '0; oc_n = '0; oa_n = '0; ol_n = 1'b1;
		unique case (state_q)
			S_RD: begin
				unique case (op_q)
					OP_SCHED: begin
						if (dly_q == '0) begin
							out_load = 1'b1; os_n = ST_ZERO;
						end else if (free_q == NIL) begin
							out_load = 1'b1; os_n = ST_FULL;
						end
					end
					OP_CANCEL: begin
						if (!hit) begin
							out_load = 1'b1; ok_n = KIND_CANCEL; os_n = ST_NOSUCH; oh_n = ch_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_EXPW: begin
				if (out_free) begin
					out_load = 1'b1; ok_n = KIND_EXPIRE;
					oh_n = 16'(32'(sv_q.hnd)); oc_n = sv_q.cb; oa_n = sv_q.arg;
					ol_n = !more;
				end
			end
			S_INS: begin
				if (sub_q == 2'd0) begin
					out_load = 1'b1; oh_n = 16'(32'(new_hnd));
				end
			end
			S_CAN: begin
				if (sub_q == 2'd2) begin
					out_load = 1'b1; ok_n = KIND_CANCEL; oh_n = ch_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer registers: one step of the operation per cycle, except while S_EXPW waits on the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_q <= '0;
			head_q <= NIL;
			free_q <= '0;
			pre_q <= NIL;
			s_q <= '0;
			prefix_q <= '0;
			dly_q <= '0;
			op_q <= OP_TICK;
			cb_q <= '0;
			arg_q <= '0;
			ch_q <= '0;
			nexp_q <= '0;
			sub_q <= '0;
			sv_q <= '0;
			pe_q <= '0;
			ov_q <= 1'b0;
			ok_q <= KIND_SCHED;
			os_q <= ST_OK;
			oh_q <= '0;
			oc_q <= '0;
			oa_q <= '0;
			ol_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				ov_q <= 1'b1;
				ok_q <= ok_n; os_q <= os_n; oh_q <= oh_n; oc_q <= oc_n; oa_q <= oa_n;
				ol_q <= ol_n;
			end else if (out_acc) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: cur_q <= cur_q + PW'(1);
				S_IDLE: if (in_acc) begin
					op_q <= in_op;
					dly_q <= DELAY_WIDTH'(in_ch.data[95:64]);
					cb_q <= in_ch.data[63:48];
					arg_q <= in_ch.data[47:16];
					ch_q <= in_ch.data[15:0];
				end
				S_RD: begin
					// rd_q now holds the addressed entry.
					sub_q <= '0;
					nexp_q <= '0;
					unique case (op_q)
						OP_TICK: begin
							cur_q <= head_q; sv_q <= rd_q;
						end
						OP_SCHED: begin
							if (dly_q != '0 && free_q != NIL) begin
								s_q <= free_q; sv_q <= rd_q;
								free_q <= rd_q.nxt;
								prefix_q <= '0; pre_q <= NIL; cur_q <= head_q;
							end
						end
						OP_CANCEL: begin
							s_q <= PW'(ch_q[IW-1:0]); sv_q <= rd_q;
						end
						default: begin
						end
					endcase
				end
				S_EXP: begin
					head_q <= sv_q.nxt;
					free_q <= cur_q;
					nexp_q <= nexp_q + 6'd1;
				end
				S_EXPW: if (out_free && more) begin
					cur_q <= sv_q.nxt;
					sv_q <= rd_q;
				end
				S_WALK: if (!brk) begin
					prefix_q <= sum;
					pre_q <= cur_q;
					pe_q <= rd_q;
					cur_q <= rd_q.nxt;
				end
				S_INS: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd2 && pre_q == NIL) head_q <= s_q;
				end
				S_CAN: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd1 && head_q == s_q) head_q <= sv_q.nxt;
					if (sub_q == 2'd2) free_q <= s_q;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A waiting result word holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ch.ready |=> ov_q && $stable(out_ch.data));
	// A result word is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free);
	// Words are only taken while the sequencer is idle.
	a_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == S_IDLE);
	// List and pool heads always name a slot or the empty marker.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NIL && free_q <= NIL);
`endif
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for delta_list_timeout_scheduler_top: directed and random words
// checked against a behavioral scheduler model kept in this file.
// Depends on dlts_pkg, dlts_stream_if and the scheduler RTL.
`timescale 1ns / 1ps
module tb_top;
	import dlts_pkg::*;

	localparam int SLOTS = 32;
	localparam int NONE = SLOTS;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] delay;
		logic [15:0] callback_id;
		logic [31:0] user_arg;
		logic [15:0] cancel_handle;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] handle;
		logic [15:0] expired_callback;
		logic [31:0] expired_arg;
		logic        last;
	} rsp_word_t;

	logic clk;
	logic arst_n;

	dlts_stream_if #(.payload_t(cmd_word_t)) cmd_ch ();
	dlts_stream_if #(.payload_t(rsp_word_t)) rsp_ch ();

	delta_list_timeout_scheduler_top #(
		.SLOTS(SLOTS),
		.DELAY_WIDTH(32),
		.HANDLE_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(cmd_ch),
		.out_ch(rsp_ch)
	);

	// Scheduler state as the testbench sees it.
	logic [31:0] tq_delta [SLOTS];
	logic [15:0] tq_handle [SLOTS];
	int          tq_next [SLOTS];
	int          tq_prev [SLOTS];
	bit          tq_active [SLOTS];
	logic [15:0] tq_callback [SLOTS];
	logic [31:0] tq_arg [SLOTS];
	int          tq_head;
	int          tq_free;

	rsp_word_t pending_rsp [$];
	int        mismatch_count;
	int        rsp_hold_cycles;
	bit        send_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic rsp_word_t mk_rsp(logic [1:0] kind, logic [1:0] status,
			logic [15:0] handle, logic [15:0] cb, logic [31:0] arg);
		rsp_word_t r;
		r.kind = kind;
		r.status = status;
		r.handle = handle;
		r.expired_callback = cb;
		r.expired_arg = arg;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic sched_reset();
		for (int i = 0; i < SLOTS; i++) begin
			tq_delta[i] = '0;
			tq_handle[i] = 16'(i);
			tq_next[i] = i + 1;
			tq_prev[i] = 0;
			tq_active[i] = 1'b0;
			tq_callback[i] = '0;
			tq_arg[i] = '0;
		end
		tq_head = NONE;
		tq_free = 0;
	endtask

	task automatic free_slot(int s);
		tq_active[s] = 1'b0;
		tq_delta[s] = '0;
		tq_prev[s] = 0;
		tq_next[s] = tq_free;
		tq_free = s;
	endtask

	// Work out the result words that one accepted command word causes.
	task automatic predict_results(cmd_word_t c);
		int h, nx, pv, s, it, pre, cnt, n;
		logic [31:0] prefix, sum;
		rsp_word_t r;
		case (c.opcode)
			OP_TICK: begin
				h = tq_head;
				if (h < NONE) begin
					n = 0;
					if (tq_delta[h] != 0)
						tq_delta[h] = tq_delta[h] - 1;
					while (n < MAX_RESULTS && h < NONE && tq_delta[h] == 0) begin
						nx = tq_next[h];
						r = mk_rsp(KIND_EXPIRE, ST_OK, tq_handle[h], tq_callback[h],
							tq_arg[h]);
						r.last = 1'b0;
						pending_rsp.push_back(r);
						n++;
						tq_head = nx;
						if (nx < NONE)
							tq_prev[nx] = NONE;
						free_slot(h);
						h = nx;
					end
					if (n > 0)
						pending_rsp[pending_rsp.size() - 1].last = 1'b1;
				end
			end
			OP_SCHED: begin
				if (c.delay == 0) begin
					pending_rsp.push_back(mk_rsp(KIND_SCHED, ST_ZERO, '0, '0, '0));
				end else if (tq_free >= NONE) begin
					pending_rsp.push_back(mk_rsp(KIND_SCHED, ST_FULL, '0, '0, '0));
				end else begin
					s = tq_free;
					tq_free = tq_next[s];
					tq_handle[s] = tq_handle[s] + 16'(SLOTS);
					tq_active[s] = 1'b1;
					tq_callback[s] = c.callback_id;
					tq_arg[s] = c.user_arg;
					prefix = '0;
					pre = NONE;
					cnt = 0;
					it = tq_head;
					while (it < NONE && cnt < SLOTS) begin
						sum = prefix + tq_delta[it];
						if (c.delay < sum)
							break;
						prefix = sum;
						pre = it;
						it = tq_next[it];
						cnt++;
					end
					tq_prev[s] = pre;
					tq_next[s] = it;
					if (it < NONE)
						tq_prev[it] = s;
					if (pre < NONE)
						tq_next[pre] = s;
					else
						tq_head = s;
					tq_delta[s] = c.delay - prefix;
					if (it < NONE)
						tq_delta[it] = tq_delta[it] - tq_delta[s];
					pending_rsp.push_back(mk_rsp(KIND_SCHED, ST_OK, tq_handle[s], '0, '0));
				end
			end
			OP_CANCEL: begin
				s = c.cancel_handle % SLOTS;
				if (!tq_active[s] || tq_handle[s] != c.cancel_handle) begin
					pending_rsp.push_back(mk_rsp(KIND_CANCEL, ST_NOSUCH, c.cancel_handle,
						'0, '0));
				end else begin
					nx = tq_next[s];
					pv = tq_prev[s];
					if (tq_head == s) begin
						tq_head = nx;
						if (nx < NONE)
							tq_prev[nx] = NONE;
					end else begin
						if (pv < NONE)
							tq_next[pv] = nx;
						if (nx < NONE)
							tq_prev[nx] = pv;
					end
					if (nx < NONE)
						tq_delta[nx] = tq_delta[nx] + tq_delta[s];
					free_slot(s);
					pending_rsp.push_back(mk_rsp(KIND_CANCEL, ST_OK, c.cancel_handle,
						'0, '0));
				end
			end
			default: begin
			end
		endcase
	endtask

	// Offer one word after a random gap (none in quiet mode) and wait until it is taken.
	task automatic send_word(logic [1:0] op, logic [31:0] delay, logic [15:0] cb,
			logic [31:0] arg, logic [15:0] hdl);
		int gap;
		cmd_word_t c;
		gap = send_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		c.opcode = op;
		c.delay = delay;
		c.callback_id = cb;
		c.user_arg = arg;
		c.cancel_handle = hdl;
		cmd_ch.data <= c;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predict_results(c);
	endtask

	task automatic send_tick();
		send_word(OP_TICK, $urandom, 16'($urandom), $urandom, 16'($urandom));
	endtask

	task automatic send_sched(logic [31:0] delay);
		send_word(OP_SCHED, delay, 16'($urandom), $urandom, 16'($urandom));
	endtask

	task automatic send_cancel(logic [15:0] hdl);
		send_word(OP_CANCEL, $urandom, 16'($urandom), $urandom, hdl);
	endtask

	// Pick the handle of a live timeout, or a random one if none is live.
	function automatic logic [15:0] live_handle();
		int s;
		s = $urandom_range(0, SLOTS - 1);
		for (int i = 0; i < SLOTS; i++)
			if (tq_active[(s + i) % SLOTS])
				return tq_handle[(s + i) % SLOTS];
		return 16'($urandom);
	endfunction

	task automatic drain_idle();
		send_quiet = 1'b0;
		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Extremes of the fields, every opcode and the listed corner cases.
	task automatic test_directed();
		logic [15:0] h;
		send_tick();
		send_sched(32'd0);
		send_word(OP_SCHED, 32'd2, 16'h0000, 32'h0000_0000, 16'hFFFF);
		send_word(OP_SCHED, 32'd2, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
		send_word(OP_SCHED, 32'd2, 16'h5A5A, 32'hA5A5_A5A5, 16'h0000);
		send_sched(32'hFFFF_FFFF);
		send_sched(32'd1);
		send_cancel(16'hFFFF);
		send_word(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		h = live_handle();
		send_cancel(h);
		send_cancel(h);
		send_cancel(16'd0);
		send_tick();
		send_tick();
		send_tick();
		send_sched(32'h8000_0000);
		send_cancel(live_handle());
		send_cancel(live_handle());
		send_tick();
		drain_idle();
	endtask

	// Fill the pool while results are held back, then free it again.
	task automatic test_pool_full();
		rsp_hold_cycles = 400;
		send_quiet = 1'b1;
		for (int i = 0; i < SLOTS + 4; i++)
			send_sched($urandom_range(1, 6));
		send_quiet = 1'b0;
		for (int i = 0; i < 8; i++)
			send_tick();
		drain_idle();
	endtask

	// Mostly well-formed traffic with small delays, some full-range noise.
	task automatic test_random();
		int pick;
		logic [31:0] d;
		for (int i = 0; i < 400; i++) begin
			if (i % 50 == 0)
				send_quiet = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_tick();
			end else if (pick < 75) begin
				case ($urandom_range(0, 9))
					0: d = $urandom;
					1: d = 32'd0;
					default: d = $urandom_range(1, 12);
				endcase
				send_sched(d);
			end else if (pick < 92) begin
				send_cancel(live_handle());
			end else if (pick < 97) begin
				send_cancel(16'($urandom));
			end else begin
				send_word(OP_UNUSED, $urandom, 16'($urandom), $urandom, 16'($urandom));
			end
		end
		drain_idle();
	endtask

	// Receiver side: random stalls, or one long hold when a test asks.
	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rsp_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
			end else begin
				n = send_quiet ? 0 : $urandom_range(0, 15);
				if (n > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Compare each taken result word with the oldest expected one.
	always @(posedge clk) begin
		rsp_word_t exp_rsp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word %p", rsp_ch.data);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_ch.data !== exp_rsp) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, got %p", exp_rsp, rsp_ch.data);
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		rsp_hold_cycles = 0;
		send_quiet = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		sched_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_full();
		test_random();
		if (mismatch_count == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
